// ===== src/thread_fetch_round_robin_picker_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the thread fetch round-robin picker
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef THREAD_FETCH_ROUND_ROBIN_PICKER_ASSERT_SVH
`define THREAD_FETCH_ROUND_ROBIN_PICKER_ASSERT_SVH

`ifndef SYNTHESIS

`define TFRR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("tfrr assertion failed");

`define TFRR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tfrr assertion failed");

`define TFRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tfrr assertion failed");

`else

`define TFRR_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define TFRR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TFRR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/tfrr_pkg.sv =====
// ----------------------------------------------------------------------------
// Thread fetch picker package
// Shared types and constants for the round-robin fetch picker.
// ----------------------------------------------------------------------------
package tfrr_pkg;

	localparam int KIND_BITS = 4;
	localparam int THREAD_BITS = 6;
	localparam int TOTAL_BITS = 7;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 7;
	localparam int COUNT_CFG_BITS = 7;
	localparam int LIVE_CFG_BITS = 6;

	localparam logic [CFG_INDEX_BITS-1:0] REG_THREAD_COUNT = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_LIVE = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SKIP_MISS = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GPU_MODE = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STALL_BRANCH = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STALL_LOAD = 3'd5;

	localparam logic [COUNT_CFG_BITS-1:0] THREAD_COUNT_RESET = 7'd64;

	typedef enum logic [KIND_BITS-1:0] {
		K_PICK = 4'd0,
		K_MISS = 4'd1,
		K_FILL = 4'd2,
		K_BR_WAIT = 4'd3,
		K_BR_READY = 4'd4,
		K_LOAD_WAIT = 4'd5,
		K_LOAD_READY = 4'd6,
		K_END = 4'd7,
		K_BLOCK = 4'd8,
		K_UNBLOCK = 4'd9
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_PICK,
		S_FILL,
		S_LOAD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [COUNT_CFG_BITS-1:0] thread_count;
		logic [LIVE_CFG_BITS-1:0] first_live;
		logic skip_miss;
		logic gpu_mode;
		logic stall_branch;
		logic stall_load;
	} cfg_t;

	typedef struct packed {
		logic set_miss;
		logic clr_miss;
		logic set_br;
		logic clr_br;
		logic set_done;
		logic set_blk;
		logic clr_blk;
		logic set_load;
		logic clr_load;
	} flag_op_t;

endpackage

// ===== src/tfrr_if.sv =====
// ----------------------------------------------------------------------------
// Thread fetch picker channels
// Event item, result and configuration write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface tfrr_item_if #(
	parameter int LINE_ADDR_BITS = 48
) ();
	logic valid;
	logic ready;
	logic [tfrr_pkg::KIND_BITS-1:0] kind;
	logic [tfrr_pkg::THREAD_BITS-1:0] thread;
	logic [LINE_ADDR_BITS-1:0] line_address;

	modport source(output valid, kind, thread, line_address, input ready);
	modport sink(input valid, kind, thread, line_address, output ready);
endinterface

interface tfrr_result_if ();
	logic valid;
	logic ready;
	logic granted;
	logic [tfrr_pkg::THREAD_BITS-1:0] granted_thread;
	logic [tfrr_pkg::TOTAL_BITS-1:0] threads_waiting_on_load;

	modport source(output valid, granted, granted_thread, threads_waiting_on_load,
		input ready);
	modport sink(input valid, granted, granted_thread, threads_waiting_on_load,
		output ready);
endinterface

interface tfrr_cfg_if ();
	logic valid;
	logic ready;
	logic [tfrr_pkg::CFG_INDEX_BITS-1:0] index;
	logic [tfrr_pkg::CFG_DATA_BITS-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== src/tfrr_ram.sv =====
// ----------------------------------------------------------------------------
// Thread fetch picker RAM
// Simple dual-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tfrr_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 48
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/tfrr_flags.sv =====
// ----------------------------------------------------------------------------
// Thread fetch picker flags
// Per-thread status flags and the fetch eligibility vector derived from them.
// ----------------------------------------------------------------------------
module tfrr_flags #(
	parameter int MAX_THREADS = 64
) (
	input logic clk,
	input logic arst_n,
	input tfrr_pkg::cfg_t cfg_q,
	input logic [((($clog2(MAX_THREADS) + 1) > 7) ? ($clog2(MAX_THREADS) + 1) : 7)-1:0]
		n_slots,
	input tfrr_pkg::flag_op_t op,
	input logic [$clog2(MAX_THREADS)-1:0] idx,
	output logic [MAX_THREADS-1:0] eligible,
	output logic [MAX_THREADS-1:0] miss_pending,
	output logic [MAX_THREADS-1:0] load_nz,
	output logic any_live
);

	localparam int IW = $clog2(MAX_THREADS);
	localparam int CW = ((IW + 1) > 7) ? (IW + 1) : 7;

	logic [MAX_THREADS-1:0] miss_q;
	logic [MAX_THREADS-1:0] br_q;
	logic [MAX_THREADS-1:0] done_q;
	logic [MAX_THREADS-1:0] blk_q;
	logic [MAX_THREADS-1:0] lnz_q;
	logic [CW-1:0] lo_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_q <= '0;
			br_q <= '0;
			done_q <= '0;
			blk_q <= '0;
			lnz_q <= '0;
		end else begin
			if (op.set_miss) begin
				miss_q[idx] <= 1'b1;
			end
			if (op.clr_miss) begin
				miss_q[idx] <= 1'b0;
			end
			if (op.set_br) begin
				br_q[idx] <= 1'b1;
			end
			if (op.clr_br) begin
				br_q[idx] <= 1'b0;
			end
			if (op.set_done) begin
				done_q[idx] <= 1'b1;
			end
			if (op.set_blk) begin
				blk_q[idx] <= 1'b1;
			end
			if (op.clr_blk) begin
				blk_q[idx] <= 1'b0;
			end
			if (op.set_load) begin
				lnz_q[idx] <= 1'b1;
			end
			if (op.clr_load) begin
				lnz_q[idx] <= 1'b0;
			end
		end
	end

	always_comb begin
		lo_ext = CW'(cfg_q.first_live);
		any_live = 1'b0;
		for (int i = 0; i < MAX_THREADS; i++) begin
			eligible[i] = !done_q[i] && !blk_q[i]
				&& !(cfg_q.skip_miss && miss_q[i])
				&& !(cfg_q.gpu_mode && ((cfg_q.stall_branch && br_q[i])
					|| (cfg_q.stall_load && lnz_q[i])));
			if ((CW'(i) >= lo_ext) && (CW'(i) < n_slots) && !done_q[i]) begin
				any_live = 1'b1;
			end
		end
	end

	assign miss_pending = miss_q;
	assign load_nz = lnz_q;

endmodule

// ===== src/thread_fetch_round_robin_picker.sv =====
// ----------------------------------------------------------------------------
// Thread fetch round-robin picker: per-thread events and round-robin fetch pick
// Flag events go to S_DONE, load events via S_LOAD to S_DONE, a pick via S_MOD (pointer
// wrap steps) and S_PICK (live slots tried, one per cycle) to S_DONE, and a fill via S_FILL,
// reading one miss-line entry per cycle. Items are taken one at a time, and a stalled
// result adds its wait. Reset clears all flags, counters and the pointer.
// ----------------------------------------------------------------------------
`include "thread_fetch_round_robin_picker_assert.svh"

module thread_fetch_round_robin_picker #(
	parameter int MAX_THREADS = 64,
	parameter int LINE_ADDR_BITS = 48,
	parameter int LOAD_COUNT_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	tfrr_item_if.sink item,
	tfrr_result_if.source result,
	tfrr_cfg_if.sink cfg
);

	localparam int IW = $clog2(MAX_THREADS);
	localparam int CW = ((IW + 1) > 7) ? (IW + 1) : 7;
	localparam int TB = tfrr_pkg::THREAD_BITS;
	localparam int NB = tfrr_pkg::TOTAL_BITS;

	tfrr_pkg::state_t state_q;
	tfrr_pkg::state_t state_d;
	tfrr_pkg::cfg_t cfg_q;
	tfrr_pkg::kind_t kind_q;
	tfrr_pkg::kind_t in_kind;
	tfrr_pkg::flag_op_t flag_op;

	logic [CW-1:0] n_slots;
	logic [CW-1:0] lo_ext;
	logic [CW-1:0] ptr_ext;
	logic [CW-1:0] ptr_nxt;
	logic [CW-1:0] tries_q;
	logic [CW-1:0] fill_idx_q;
	logic range_ok;
	logic thread_ok;
	logic in_fire;
	logic out_free;
	logic pick_go;
	logic pick_hit;

	logic [IW-1:0] thread_idx;
	logic [IW-1:0] ptr_q;
	logic [IW-1:0] ptr_adv;
	logic [IW-1:0] tidx_q;
	logic [IW-1:0] gid_q;
	logic [IW-1:0] fill_idx_s1;
	logic [IW-1:0] flag_idx;
	logic [LINE_ADDR_BITS-1:0] line_q;
	logic [LINE_ADDR_BITS-1:0] miss_rd;
	logic grant_q;
	logic fill_v_s1;
	logic fill_issue;
	logic fill_hit;
	logic miss_we;
	logic miss_re;
	logic ld_we;
	logic ld_re;

	logic [LOAD_COUNT_BITS-1:0] ld_rd;
	logic [LOAD_COUNT_BITS-1:0] ld_cnt;
	logic [LOAD_COUNT_BITS-1:0] ld_new;
	logic ld_first;
	logic ld_last;
	logic [NB-1:0] total_q;

	logic [MAX_THREADS-1:0] elig;
	logic [MAX_THREADS-1:0] pend;
	logic [MAX_THREADS-1:0] lnz;
	logic any_live;

	logic out_valid_q;
	logic out_granted_q;
	logic [TB-1:0] out_thread_q;
	logic [NB-1:0] out_total_q;

	tfrr_flags #(
		.MAX_THREADS(MAX_THREADS)
	) u_flags (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_q(cfg_q),
		.n_slots(n_slots),
		.op(flag_op),
		.idx(flag_idx),
		.eligible(elig),
		.miss_pending(pend),
		.load_nz(lnz),
		.any_live(any_live)
	);

	tfrr_ram #(
		.DEPTH(MAX_THREADS),
		.WIDTH(LINE_ADDR_BITS)
	) u_miss_ram (
		.clk(clk),
		.we(miss_we),
		.waddr(thread_idx),
		.wdata(item.line_address),
		.re(miss_re),
		.raddr(fill_idx_q[IW-1:0]),
		.rdata(miss_rd)
	);

	tfrr_ram #(
		.DEPTH(MAX_THREADS),
		.WIDTH(LOAD_COUNT_BITS)
	) u_load_ram (
		.clk(clk),
		.we(ld_we),
		.waddr(tidx_q),
		.wdata(ld_new),
		.re(ld_re),
		.raddr(thread_idx),
		.rdata(ld_rd)
	);

	assign in_kind = tfrr_pkg::kind_t'(item.kind);
	assign in_fire = item.valid && item.ready;
	assign out_free = !out_valid_q || result.ready;
	assign item.ready = (state_q == tfrr_pkg::S_IDLE);
	assign cfg.ready = 1'b1;

	assign n_slots = (CW'(cfg_q.thread_count) < CW'(MAX_THREADS))
		? CW'(cfg_q.thread_count) : CW'(MAX_THREADS);
	assign lo_ext = CW'(cfg_q.first_live);
	assign range_ok = (n_slots != '0) && (lo_ext < n_slots);
	assign pick_go = range_ok && any_live;
	assign pick_hit = (state_q == tfrr_pkg::S_PICK) && elig[ptr_q];
	assign thread_ok = CW'(item.thread) < CW'(MAX_THREADS);
	assign thread_idx = IW'(item.thread);

	always_comb begin
		ptr_ext = CW'(ptr_q);
		ptr_nxt = CW'(ptr_ext + CW'(1));
		if (ptr_nxt == n_slots) begin
			ptr_nxt = '0;
		end
		if (ptr_nxt < lo_ext) begin
			ptr_nxt = lo_ext;
		end
		ptr_adv = IW'(ptr_nxt);
	end

	assign fill_issue = fill_idx_q < n_slots;
	assign fill_hit = fill_v_s1 && pend[fill_idx_s1] && (miss_rd == line_q);

	always_comb begin
		ld_cnt = lnz[tidx_q] ? ld_rd : '0;
		ld_first = (kind_q == tfrr_pkg::K_LOAD_WAIT) && !lnz[tidx_q];
		ld_last = (kind_q == tfrr_pkg::K_LOAD_READY) && lnz[tidx_q]
			&& (ld_cnt == LOAD_COUNT_BITS'(1));
		if (kind_q == tfrr_pkg::K_LOAD_WAIT) begin
			ld_new = (ld_cnt == '1) ? ld_cnt : LOAD_COUNT_BITS'(ld_cnt + LOAD_COUNT_BITS'(1));
		end else begin
			ld_new = LOAD_COUNT_BITS'(ld_cnt - LOAD_COUNT_BITS'(1));
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tfrr_pkg::S_IDLE: begin
				if (in_fire) begin
					case (in_kind)
						tfrr_pkg::K_PICK: state_d = pick_go ? tfrr_pkg::S_MOD : tfrr_pkg::S_DONE;
						tfrr_pkg::K_FILL: state_d = range_ok ? tfrr_pkg::S_FILL : tfrr_pkg::S_DONE;
						tfrr_pkg::K_LOAD_WAIT, tfrr_pkg::K_LOAD_READY: begin
							state_d = thread_ok ? tfrr_pkg::S_LOAD : tfrr_pkg::S_DONE;
						end
						default: state_d = tfrr_pkg::S_DONE;
					endcase
				end
			end
			tfrr_pkg::S_MOD: begin
				if (ptr_ext < n_slots) begin
					state_d = tfrr_pkg::S_PICK;
				end
			end
			tfrr_pkg::S_PICK: begin
				if (elig[ptr_q] || (tries_q == CW'(1))) begin
					state_d = tfrr_pkg::S_DONE;
				end
			end
			tfrr_pkg::S_FILL: begin
				if (!fill_issue && !fill_v_s1) begin
					state_d = tfrr_pkg::S_DONE;
				end
			end
			tfrr_pkg::S_LOAD: state_d = tfrr_pkg::S_DONE;
			tfrr_pkg::S_DONE: begin
				if (out_free) begin
					state_d = tfrr_pkg::S_IDLE;
				end
			end
			default: state_d = tfrr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		flag_op = '0;
		flag_idx = thread_idx;
		miss_we = 1'b0;
		miss_re = 1'b0;
		ld_we = 1'b0;
		ld_re = 1'b0;
		case (state_q)
			tfrr_pkg::S_IDLE: begin
				if (in_fire && thread_ok) begin
					case (in_kind)
						tfrr_pkg::K_MISS: begin
							flag_op.set_miss = 1'b1;
							miss_we = 1'b1;
						end
						tfrr_pkg::K_BR_WAIT: flag_op.set_br = 1'b1;
						tfrr_pkg::K_BR_READY: flag_op.clr_br = 1'b1;
						tfrr_pkg::K_END: flag_op.set_done = 1'b1;
						tfrr_pkg::K_BLOCK: flag_op.set_blk = 1'b1;
						tfrr_pkg::K_UNBLOCK: flag_op.clr_blk = 1'b1;
						tfrr_pkg::K_LOAD_WAIT, tfrr_pkg::K_LOAD_READY: ld_re = 1'b1;
						default: ;
					endcase
				end
			end
			tfrr_pkg::S_FILL: begin
				flag_idx = fill_idx_s1;
				miss_re = fill_issue;
				flag_op.clr_miss = fill_hit;
			end
			tfrr_pkg::S_LOAD: begin
				flag_idx = tidx_q;
				ld_we = (kind_q == tfrr_pkg::K_LOAD_WAIT) || lnz[tidx_q];
				flag_op.set_load = (kind_q == tfrr_pkg::K_LOAD_WAIT);
				flag_op.clr_load = ld_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thread_count <= tfrr_pkg::THREAD_COUNT_RESET;
			cfg_q.first_live <= '0;
			cfg_q.skip_miss <= 1'b0;
			cfg_q.gpu_mode <= 1'b0;
			cfg_q.stall_branch <= 1'b0;
			cfg_q.stall_load <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				tfrr_pkg::REG_THREAD_COUNT: begin
					cfg_q.thread_count <= cfg.data[tfrr_pkg::COUNT_CFG_BITS-1:0];
				end
				tfrr_pkg::REG_FIRST_LIVE: begin
					cfg_q.first_live <= cfg.data[tfrr_pkg::LIVE_CFG_BITS-1:0];
				end
				tfrr_pkg::REG_SKIP_MISS: cfg_q.skip_miss <= cfg.data[0];
				tfrr_pkg::REG_GPU_MODE: cfg_q.gpu_mode <= cfg.data[0];
				tfrr_pkg::REG_STALL_BRANCH: cfg_q.stall_branch <= cfg.data[0];
				tfrr_pkg::REG_STALL_LOAD: cfg_q.stall_load <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfrr_pkg::S_IDLE;
			ptr_q <= '0;
			tries_q <= '0;
			fill_idx_q <= '0;
			fill_v_s1 <= 1'b0;
			grant_q <= 1'b0;
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == tfrr_pkg::S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_fire) begin
				grant_q <= 1'b0;
				tries_q <= CW'(n_slots - lo_ext);
				fill_idx_q <= lo_ext;
				fill_v_s1 <= 1'b0;
			end
			case (state_q)
				tfrr_pkg::S_MOD: begin
					if (ptr_ext >= n_slots) begin
						ptr_q <= IW'(ptr_ext - n_slots);
					end
				end
				tfrr_pkg::S_PICK: begin
					ptr_q <= ptr_adv;
					tries_q <= CW'(tries_q - CW'(1));
					if (elig[ptr_q]) begin
						grant_q <= 1'b1;
					end
				end
				tfrr_pkg::S_FILL: begin
					fill_v_s1 <= fill_issue;
					if (fill_issue) begin
						fill_idx_q <= CW'(fill_idx_q + CW'(1));
					end
				end
				tfrr_pkg::S_LOAD: begin
					if (ld_first) begin
						total_q <= NB'(total_q + NB'(1));
					end
					if (ld_last && (total_q != '0)) begin
						total_q <= NB'(total_q - NB'(1));
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= in_kind;
			tidx_q <= thread_idx;
			line_q <= item.line_address;
		end
		if ((state_q == tfrr_pkg::S_PICK) && elig[ptr_q]) begin
			gid_q <= ptr_q;
		end
		fill_idx_s1 <= fill_idx_q[IW-1:0];
		if ((state_q == tfrr_pkg::S_DONE) && out_free) begin
			out_granted_q <= grant_q;
			out_thread_q <= grant_q ? TB'(gid_q) : '0;
			out_total_q <= total_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.granted = out_granted_q;
	assign result.granted_thread = out_thread_q;
	assign result.threads_waiting_on_load = out_total_q;

	`TFRR_ASSERT_ALWAYS(a_total_matches, clk, arst_n, int'(total_q) == $countones(lnz))
	`TFRR_ASSERT_IMPL(a_fill_stage, clk, arst_n, fill_v_s1, state_q == tfrr_pkg::S_FILL)
	`TFRR_ASSERT_NEXT(a_pick_grant, clk, arst_n, pick_hit, grant_q && (state_q == tfrr_pkg::S_DONE))

endmodule
